// ===== rtl/velocity_rescale_thermostat_assert.svh =====
// Assertion macros for the velocity rescale thermostat.
`ifndef VELOCITY_RESCALE_THERMOSTAT_ASSERT_SVH
`define VELOCITY_RESCALE_THERMOSTAT_ASSERT_SVH
`ifndef SYNTHESIS
`define VRT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define VRT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define VRT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define VRT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/vrt_pkg.sv =====
// Shared types and constants of the velocity rescale thermostat.
package vrt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIMS      = 3;
  localparam int LIM_W     = 64;
  localparam int NLIM_W    = LIM_W + FRAC_BITS + 1;
  localparam int REM_W     = NLIM_W + 64;
  localparam int DEN_W     = 96;
  localparam int G_W       = 32;
  localparam int GD_W      = DEN_W + G_W;
  localparam int TRY_W     = GD_W + G_W + 2;
  localparam int STEPS     = G_W;

  typedef enum logic [2:0] {
    REG_MASS   = 3'd0,
    REG_SCALE  = 3'd1,
    REG_FMIN   = 3'd2,
    REG_FMAX   = 3'd3,
    REG_LIMIT  = 3'd4,
    REG_TEMP   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] mass;
    logic [31:0] scale;
    logic [31:0] fmin;
    logic [31:0] fmax;
    logic [31:0] limit;
    logic [31:0] temp;
  } cfg_t;

  // Per-particle fields that travel the whole pipeline
  typedef struct packed {
    logic [DIMS-1:0][31:0] mag;
    logic [DIMS-1:0]       neg;
    logic                  last;
    logic                  plain;
  } base_t;

  // Square-root search state
  typedef struct packed {
    base_t              base;
    logic               clamp;
    logic [REM_W-1:0]   rem;
    logic [GD_W-1:0]    gd;
    logic [DEN_W-1:0]   den;
    logic [G_W-1:0]     g;
  } sq_t;

  typedef struct packed {
    logic [DIMS-1:0][31:0] vel;
    logic                  clamped;
    logic                  last;
  } res_t;

endpackage

// ===== rtl/vrt_if.sv =====
// Stream interfaces for velocity items and rescaled results.
interface vrt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic               last_particle;

  modport source(output valid, vel_x, vel_y, vel_z, last_particle, input ready);
  modport sink(input valid, vel_x, vel_y, vel_z, last_particle, output ready);
endinterface

interface vrt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;
  logic               energy_clamped;
  logic               last_result;

  modport source(output valid, new_vel_x, new_vel_y, new_vel_z, energy_clamped,
                 last_result, input ready);
  modport sink(input valid, new_vel_x, new_vel_y, new_vel_z, energy_clamped,
               last_result, output ready);
endinterface

// ===== rtl/vrt_front.sv =====
// Front stages: magnitudes, squared speed, energy product and limit compare.
module vrt_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [vrt_pkg::DIMS-1:0][31:0] vel_i,
  input  logic                         last_i,
  input  vrt_pkg::cfg_t                cfg_i,
  output logic                         valid_o,
  output vrt_pkg::sq_t                 sq_o
);

  logic [4:0]                          vld_q;
  vrt_pkg::base_t                      b1_q, b2_q, b3_q, b4_q;
  vrt_pkg::base_t                      b1_d;
  logic [vrt_pkg::DIMS-1:0][63:0]      sq_q;
  logic [63:0]                         s_q;
  logic [63:0]                         plo_q, phi_q;
  logic [vrt_pkg::LIM_W-1:0]           lim_q;
  logic [vrt_pkg::DEN_W-1:0]           den;
  logic [vrt_pkg::NLIM_W-1:0]          nlim;
  vrt_pkg::sq_t                        sq_d, sq_q5;

  // Take magnitudes and the plain-range decision
  always_comb begin
    for (int d = 0; d < vrt_pkg::DIMS; d++) begin
      b1_d.neg[d] = vel_i[d][31];
      b1_d.mag[d] = vel_i[d][31] ? (~vel_i[d] + 32'd1) : vel_i[d];
    end
    b1_d.last  = last_i;
    b1_d.plain = (cfg_i.scale >= cfg_i.fmin) && (cfg_i.scale <= cfg_i.fmax);
  end

  // Energy product and first remainder of the root search
  always_comb begin
    den  = {phi_q, 32'd0} + vrt_pkg::DEN_W'(plo_q);
    nlim = {lim_q, {(vrt_pkg::FRAC_BITS + 1){1'b0}}};
    sq_d.base  = b4_q;
    sq_d.clamp = !b4_q.plain && (vrt_pkg::TRY_W'(den) > vrt_pkg::TRY_W'(nlim));
    sq_d.rem   = {nlim, 64'd0};
    sq_d.gd    = '0;
    sq_d.den   = den;
    sq_d.g     = '0;
  end

  // Track the energy limit from the registers
  always_ff @(posedge clk_i) begin
    lim_q <= vrt_pkg::LIM_W'(cfg_i.limit) * vrt_pkg::LIM_W'(cfg_i.temp);
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_q <= b1_d;
      b2_q <= b1_q;
      for (int d = 0; d < vrt_pkg::DIMS; d++) begin
        sq_q[d] <= 64'(b1_q.mag[d]) * 64'(b1_q.mag[d]);
      end
      b3_q  <= b2_q;
      s_q   <= sq_q[0] + sq_q[1] + sq_q[2];
      b4_q  <= b3_q;
      plo_q <= 64'(s_q[31:0]) * 64'(cfg_i.mass);
      phi_q <= 64'(s_q[63:32]) * 64'(cfg_i.mass);
      sq_q5 <= sq_d;
    end
  end

  assign valid_o = vld_q[4];
  assign sq_o    = sq_q5;

endmodule

// ===== rtl/vrt_sqrt_step.sv =====
// One bit of the restoring root search for the energy clamp factor.
module vrt_sqrt_step (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [4:0]   bit_i,
  input  logic         valid_i,
  input  vrt_pkg::sq_t sq_i,
  output logic         valid_o,
  output vrt_pkg::sq_t sq_o
);

  logic [vrt_pkg::TRY_W-1:0] trial;
  logic [vrt_pkg::TRY_W:0]   diff;
  logic                      take;
  logic [5:0]                sh_gd, sh_den;
  vrt_pkg::sq_t              sq_d, sq_q;
  logic                      vld_q;

  // Try setting this bit: compare the growth of g^2*den with the remainder
  always_comb begin
    sh_gd  = {1'b0, bit_i} + 6'd1;
    sh_den = {bit_i, 1'b0};
    trial  = (vrt_pkg::TRY_W'(sq_i.gd) << sh_gd) + (vrt_pkg::TRY_W'(sq_i.den) << sh_den);
    diff   = {1'b0, vrt_pkg::TRY_W'(sq_i.rem)} - {1'b0, trial};
    take   = !diff[vrt_pkg::TRY_W];
    sq_d   = sq_i;
    if (take) begin
      sq_d.rem = diff[vrt_pkg::REM_W-1:0];
      sq_d.gd  = sq_i.gd + (vrt_pkg::GD_W'(sq_i.den) << bit_i);
      sq_d.g   = sq_i.g | (vrt_pkg::G_W'(1) << bit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign valid_o = vld_q;
  assign sq_o    = sq_q;

endmodule

// ===== rtl/vrt_back.sv =====
// Back stages: scale each component, round, saturate and select the result.
module vrt_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  vrt_pkg::sq_t sq_i,
  input  logic [31:0]  scale_i,
  output logic         valid_o,
  output vrt_pkg::res_t res_o
);

  localparam logic [64:0] HALF_F = 65'(1) << (vrt_pkg::FRAC_BITS - 1);
  localparam logic [64:0] HALF_G = 65'(1) << 31;

  logic [1:0]                           vld_q;
  vrt_pkg::base_t                       b_q;
  logic                                 clamp_q;
  logic [31:0]                          factor;
  logic [vrt_pkg::DIMS-1:0][63:0]       prod_q;
  logic [vrt_pkg::DIMS-1:0][64:0]       rnd;
  logic [vrt_pkg::DIMS-1:0][31:0]       sat, raw;
  vrt_pkg::res_t                        res_d, res_q;

  assign factor = sq_i.base.plain ? scale_i : sq_i.g;

  // Round on the magnitude, saturate, restore the sign
  always_comb begin
    for (int d = 0; d < vrt_pkg::DIMS; d++) begin
      if (b_q.plain) begin
        rnd[d] = (65'(prod_q[d]) + HALF_F) >> vrt_pkg::FRAC_BITS;
      end else begin
        rnd[d] = (65'(prod_q[d]) + HALF_G) >> 32;
      end
      if (b_q.neg[d]) begin
        sat[d] = (rnd[d] > 65'h80000000) ? 32'h80000000 : rnd[d][31:0];
        sat[d] = ~sat[d] + 32'd1;
      end else begin
        sat[d] = (rnd[d] > 65'h7FFFFFFF) ? 32'h7FFFFFFF : rnd[d][31:0];
      end
      raw[d] = b_q.neg[d] ? (~b_q.mag[d] + 32'd1) : b_q.mag[d];
      res_d.vel[d] = (b_q.plain || clamp_q) ? sat[d] : raw[d];
    end
    res_d.clamped = clamp_q;
    res_d.last    = b_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  // Multiply, then hold the finished result
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q     <= sq_i.base;
      clamp_q <= sq_i.clamp;
      for (int d = 0; d < vrt_pkg::DIMS; d++) begin
        prod_q[d] <= 64'(sq_i.base.mag[d]) * 64'(factor);
      end
      res_q <= res_d;
    end
  end

  assign valid_o = vld_q[1];
  assign res_o   = res_q;

endmodule

// ===== rtl/velocity_rescale_thermostat.sv =====
// Velocity rescale thermostat: one velocity vector in, one rescaled vector out.
// Datapath: 5 energy stages, 32 root-search stages and 2 scaling stages.
// Throughput: one transaction per cycle; a stalled output holds the whole pipeline.
// Reset: asynchronous, clears all valid bits and loads register defaults.
`include "velocity_rescale_thermostat_assert.svh"
module velocity_rescale_thermostat (
  input  logic        clk_i,
  input  logic        rst_ni,
  vrt_in_if.sink      in_if,
  vrt_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  vrt_pkg::cfg_t                  cfg_q;
  logic                           pipe_en;
  logic [vrt_pkg::STEPS:0]        vld;
  vrt_pkg::sq_t                   sq [vrt_pkg::STEPS+1];
  vrt_pkg::res_t                  res;
  logic                           res_vld;
  logic [vrt_pkg::DIMS-1:0][31:0] vel_in;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mass  <= 32'd65536;
      cfg_q.scale <= 32'd65536;
      cfg_q.fmin  <= 32'd0;
      cfg_q.fmax  <= 32'd131072;
      cfg_q.limit <= 32'd65536;
      cfg_q.temp  <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vrt_pkg::REG_MASS:  cfg_q.mass  <= cfg_data_i;
        vrt_pkg::REG_SCALE: cfg_q.scale <= cfg_data_i;
        vrt_pkg::REG_FMIN:  cfg_q.fmin  <= cfg_data_i;
        vrt_pkg::REG_FMAX:  cfg_q.fmax  <= cfg_data_i;
        vrt_pkg::REG_LIMIT: cfg_q.limit <= cfg_data_i;
        vrt_pkg::REG_TEMP:  cfg_q.temp  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless the output transaction is stuck
  assign pipe_en     = !res_vld || out_if.ready;
  assign in_if.ready = pipe_en;

  assign vel_in = {in_if.vel_z, in_if.vel_y, in_if.vel_x};

  vrt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_if.valid),
    .vel_i   (vel_in),
    .last_i  (in_if.last_particle),
    .cfg_i   (cfg_q),
    .valid_o (vld[0]),
    .sq_o    (sq[0])
  );

  // Root search, most significant bit first
  for (genvar k = 0; k < vrt_pkg::STEPS; k++) begin : g_step
    vrt_sqrt_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .bit_i   (5'(vrt_pkg::STEPS - 1 - k)),
      .valid_i (vld[k]),
      .sq_i    (sq[k]),
      .valid_o (vld[k+1]),
      .sq_o    (sq[k+1])
    );
  end

  vrt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (vld[vrt_pkg::STEPS]),
    .sq_i    (sq[vrt_pkg::STEPS]),
    .scale_i (cfg_q.scale),
    .valid_o (res_vld),
    .res_o   (res)
  );

  assign out_if.valid          = res_vld;
  assign out_if.new_vel_x      = res.vel[0];
  assign out_if.new_vel_y      = res.vel[1];
  assign out_if.new_vel_z      = res.vel[2];
  assign out_if.energy_clamped = res.clamped;
  assign out_if.last_result    = res.last;

  // A clamped particle never took the plain scaling path
  `VRT_ASSERT_IMP(a_clamp_not_plain, clk_i, rst_ni, vld[vrt_pkg::STEPS], !(sq[vrt_pkg::STEPS].clamp && sq[vrt_pkg::STEPS].base.plain))
  // A stall freezes every root-search stage
  `VRT_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, !pipe_en, $stable(vld))

endmodule
